@@ rtl/crsd_pkg.sv @@
// Shared constants and types for the column RLE sprite decoder.
`timescale 1ns / 1ps
`default_nettype none

package crsd_pkg;

  localparam int ROW_STRIDE = 80;

  localparam int ADDR_W     = 20;
  localparam int DEST_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int PLANE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TOTAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SEGMENT = 2'd3;

  // Request to the offset unit: plain row step, or a row skip of a byte's worth of rows.
  typedef struct packed {
    logic              row_skip;
    logic [BYTE_W-1:0] rows;
  } step_req_t;

endpackage

`default_nettype wire

@@ rtl/crsd_if.sv @@
// Valid/ready channel interfaces for compressed bytes and pixel writes.
`timescale 1ns / 1ps
`default_nettype none

interface crsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface crsd_write_if;
  logic        valid;
  logic        ready;
  logic [19:0] write_address;
  logic [3:0]  plane_mask;
  logic [7:0]  pixel_value;
  logic        last;
  logic        frame_done;

  modport source (output valid, output write_address, output plane_mask,
                  output pixel_value, output last, output frame_done, input ready);
  modport sink   (input valid, input write_address, input plane_mask,
                  input pixel_value, input last, input frame_done, output ready);
endinterface

`default_nettype wire

@@ rtl/crsd_dest_unit.sv @@
// Shared offset adder and video address generator.
`timescale 1ns / 1ps
`default_nettype none

module crsd_dest_unit (
  input  wire logic [crsd_pkg::DEST_W-1:0] dest,
  input  wire crsd_pkg::step_req_t         req,
  input  wire logic [15:0]                 page_segment,
  input  wire logic [7:0]                  origin_y,
  output logic [crsd_pkg::DEST_W-1:0]      dest_stepped,
  output logic [crsd_pkg::ADDR_W-1:0]      address
);
  import crsd_pkg::*;

  logic [31:0] step_amt;
  logic [31:0] row_base;
  logic [31:0] addr_sum;

  // Step by one row, or by a row-skip count of rows.
  always_comb begin
    if (req.row_skip) begin
      step_amt = 32'(ROW_STRIDE) * {24'b0, req.rows};
    end else begin
      step_amt = 32'(ROW_STRIDE);
    end
  end

  assign dest_stepped = dest + step_amt[DEST_W-1:0];

  assign row_base = 32'(ROW_STRIDE) * {24'b0, origin_y};
  assign addr_sum = {12'b0, page_segment, 4'b0} + row_base + {16'b0, dest};
  assign address  = addr_sum[ADDR_W-1:0];

endmodule

`default_nettype wire

@@ rtl/column_rle_sprite_decoder_top.sv @@
// Top level of the column RLE sprite decoder: byte parser, write sequencer, config registers.
`timescale 1ns / 1ps
`default_nettype none

// Takes compressed sprite frame data one byte per transfer and produces pixel writes
// for planar 320-wide video memory. A byte with frame_start set restarts column state from
// origin_x and column_total and is parsed as a column type byte. A byte that causes no
// write is only parsed. A byte that causes n writes (one for a raw or plain data byte,
// up to 32 for the value byte of a repeat) is parsed, then its writes go one write a cycle
// into the output register, paced by the single shared offset adder that steps the
// destination down one row per write. Input is held off while writes are being produced;
// a stalled sink stretches that time. The address of each write uses the register values
// current at the time, so write configuration only while the block is idle.
module column_rle_sprite_decoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  crsd_byte_if.sink                          byte_stream,
  crsd_write_if.source                       pixel_writes,
  input  wire logic                          write_enable,
  input  wire logic [crsd_pkg::CFG_IDX_W-1:0]  register_index,
  input  wire logic [crsd_pkg::CFG_DATA_W-1:0] write_data
);
  import crsd_pkg::*;

  // Parse phases
  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_SEQLEN = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_RPTVAL = 3'd5;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Configuration registers
  logic [8:0]  origin_x;
  logic [7:0]  origin_y;
  logic [8:0]  column_total;
  logic [15:0] page_segment;

  // Parser state
  logic [2:0]        parse_phase,        parse_phase_next;
  logic              column_kind,        column_kind_next;
  logic [8:0]        columns_left,       columns_left_next;
  logic [PLANE_W-1:0] current_plane,     current_plane_next;
  logic [6:0]        column_byte_offset, column_byte_offset_next;
  logic [DEST_W-1:0] dest_offset,        dest_offset_next;
  logic [7:0]        packet_left,        packet_left_next;
  logic [7:0]        sequence_left,      sequence_left_next;
  logic [5:0]        repeat_count,       repeat_count_next;

  // Write sequencer
  logic              st,          st_next;
  logic [5:0]        emit_count,  emit_count_next;
  logic [7:0]        pixel,       pixel_next;

  // Output register
  logic               ovalid,  ovalid_next;
  logic [ADDR_W-1:0]  oaddr,   oaddr_next;
  logic [PLANE_W-1:0] oplane,  oplane_next;
  logic [7:0]         opix,    opix_next;
  logic               olast,   olast_next;
  logic               odone,   odone_next;

  logic               in_xfer;
  logic               out_load;
  logic               fs;
  logic [7:0]         b;
  logic [8:0]         cl_e;
  logic [PLANE_W-1:0] plane_e;
  logic [6:0]         cbo_e;
  logic [2:0]         phase_e;
  logic [8:0]         cl_dec;
  logic               col_last;
  logic [PLANE_W-1:0] plane_rot;
  logic [6:0]         cbo_rot;
  logic               edi_col;
  logic               do_edi;
  logic               do_endcol;
  logic [7:0]         rpt_raw;

  step_req_t          req;
  logic [DEST_W-1:0]  dest_stepped;
  logic [ADDR_W-1:0]  address;

  crsd_dest_unit u_dest (
    .dest         (dest_offset),
    .req          (req),
    .page_segment (page_segment),
    .origin_y     (origin_y),
    .dest_stepped (dest_stepped),
    .address      (address)
  );

  assign byte_stream.ready = (st == ST_IDLE);
  assign in_xfer  = byte_stream.valid && byte_stream.ready;
  assign out_load = (st == ST_EMIT) && (!ovalid || pixel_writes.ready);
  assign b        = byte_stream.data_byte;
  assign fs       = in_xfer && byte_stream.frame_start;
  assign rpt_raw  = b - 8'd223;

  // Column state as seen by this cycle, with a frame restart folded in.
  assign cl_e    = fs ? column_total : columns_left;
  assign plane_e = fs ? (4'b0001 << origin_x[1:0]) : current_plane;
  assign cbo_e   = fs ? origin_x[8:2] : column_byte_offset;
  assign phase_e = fs ? PH_TYPE : parse_phase;

  // End-of-column arithmetic: count down, rotate plane, advance byte after plane 8.
  assign cl_dec    = cl_e - 9'd1;
  assign col_last  = (cl_dec == 9'd0);
  assign plane_rot = (plane_e == 4'b1000) ? 4'b0001 : (plane_e << 1);
  assign cbo_rot   = (plane_e == 4'b1000) ? (cbo_e + 7'd1) : cbo_e;

  // End of a data item closes the column once sequence and packet are both spent.
  assign edi_col = (sequence_left == 8'd0) && (packet_left == 8'd0);

  always_comb begin
    parse_phase_next        = parse_phase;
    column_kind_next        = column_kind;
    columns_left_next       = columns_left;
    current_plane_next      = current_plane;
    column_byte_offset_next = column_byte_offset;
    dest_offset_next        = dest_offset;
    packet_left_next        = packet_left;
    sequence_left_next      = sequence_left;
    repeat_count_next       = repeat_count;
    st_next                 = st;
    emit_count_next         = emit_count;
    pixel_next              = pixel;
    ovalid_next             = ovalid && !pixel_writes.ready;
    oaddr_next              = oaddr;
    oplane_next             = oplane;
    opix_next               = opix;
    olast_next              = olast;
    odone_next              = odone;
    req.row_skip            = 1'b0;
    req.rows                = b;
    do_edi                  = 1'b0;
    do_endcol               = 1'b0;

    if (in_xfer) begin
      columns_left_next       = cl_e;
      current_plane_next      = plane_e;
      column_byte_offset_next = cbo_e;
      parse_phase_next        = phase_e;
      // Drop bytes while no frame is active.
      if (cl_e != 9'd0) begin
        unique case (phase_e)
          PH_TYPE: begin
            dest_offset_next = {9'b0, cbo_e};
            if (b == 8'h00 || b == 8'h80) begin
              column_kind_next = b[7];
              parse_phase_next = PH_COUNT;
            end else begin
              do_endcol = 1'b1;
            end
          end
          PH_COUNT: begin
            packet_left_next = b;
            parse_phase_next = PH_SEQLEN;
          end
          PH_SEQLEN: begin
            sequence_left_next = b;
            parse_phase_next   = PH_SKIP;
          end
          PH_SKIP: begin
            req.row_skip     = 1'b1;
            dest_offset_next = dest_stepped;
            packet_left_next = packet_left - (sequence_left + 8'd2);
            parse_phase_next = PH_DATA;
          end
          PH_DATA: begin
            if (column_kind && b >= 8'd224) begin
              repeat_count_next  = rpt_raw[5:0];
              sequence_left_next = sequence_left - 8'd1;
              parse_phase_next   = PH_RPTVAL;
            end else begin
              pixel_next      = b;
              emit_count_next = 6'd1;
              st_next         = ST_EMIT;
            end
          end
          PH_RPTVAL: begin
            pixel_next = b;
            if (repeat_count != 6'd0) begin
              emit_count_next = repeat_count;
              st_next         = ST_EMIT;
            end else begin
              do_edi = 1'b1;
            end
          end
          default: begin
            parse_phase_next = PH_TYPE;
          end
        endcase
      end
    end else if (out_load) begin
      // Load one write, then advance one row.
      ovalid_next      = 1'b1;
      oaddr_next       = address;
      oplane_next      = current_plane;
      opix_next        = pixel;
      olast_next       = (emit_count == 6'd1);
      odone_next       = (emit_count == 6'd1) && edi_col && col_last;
      dest_offset_next = dest_stepped;
      emit_count_next  = emit_count - 6'd1;
      if (emit_count == 6'd1) begin
        do_edi  = 1'b1;
        st_next = ST_IDLE;
      end
    end

    if (do_edi) begin
      parse_phase_next = PH_DATA;
      priority if (sequence_left != 8'd0) begin
        sequence_left_next = sequence_left - 8'd1;
      end else if (packet_left != 8'd0) begin
        parse_phase_next = PH_SEQLEN;
      end else begin
        do_endcol = 1'b1;
      end
    end

    if (do_endcol) begin
      columns_left_next = cl_dec;
      parse_phase_next  = PH_TYPE;
      if (!col_last) begin
        current_plane_next      = plane_rot;
        column_byte_offset_next = cbo_rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_TYPE;
      column_kind        <= 1'b0;
      columns_left       <= 9'd0;
      current_plane      <= 4'b0001;
      column_byte_offset <= 7'd0;
      dest_offset        <= '0;
      packet_left        <= 8'd0;
      sequence_left      <= 8'd0;
      repeat_count       <= 6'd0;
      st                 <= ST_IDLE;
      emit_count         <= 6'd0;
      ovalid             <= 1'b0;
    end else begin
      parse_phase        <= parse_phase_next;
      column_kind        <= column_kind_next;
      columns_left       <= columns_left_next;
      current_plane      <= current_plane_next;
      column_byte_offset <= column_byte_offset_next;
      dest_offset        <= dest_offset_next;
      packet_left        <= packet_left_next;
      sequence_left      <= sequence_left_next;
      repeat_count       <= repeat_count_next;
      st                 <= st_next;
      emit_count         <= emit_count_next;
      ovalid             <= ovalid_next;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    pixel  <= pixel_next;
    oaddr  <= oaddr_next;
    oplane <= oplane_next;
    opix   <= opix_next;
    olast  <= olast_next;
    odone  <= odone_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= 9'd0;
      origin_y     <= 8'd0;
      column_total <= 9'd1;
      page_segment <= 16'd40960;
    end else if (write_enable) begin
      unique case (register_index)
        CFG_ORIGIN_X:     origin_x     <= write_data[8:0];
        CFG_ORIGIN_Y:     origin_y     <= write_data[7:0];
        CFG_COLUMN_TOTAL: column_total <= write_data[8:0];
        CFG_PAGE_SEGMENT: page_segment <= write_data[15:0];
        default: ;
      endcase
    end
  end

  assign pixel_writes.valid         = ovalid;
  assign pixel_writes.write_address = oaddr;
  assign pixel_writes.plane_mask    = oplane;
  assign pixel_writes.pixel_value   = opix;
  assign pixel_writes.last          = olast;
  assign pixel_writes.frame_done    = odone;

  a_plane_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(current_plane))
    else $error("plane mask lost its one-hot form");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT) |-> (emit_count != 6'd0))
    else $error("write sequencer running with no writes left");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_count == 6'd1) |=> (st == ST_IDLE && pixel_writes.valid))
    else $error("final write did not return the sequencer to idle");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_writes.valid && pixel_writes.frame_done) |-> pixel_writes.last)
    else $error("frame_done on a write that is not the last of its byte");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the column RLE sprite decoder: directed frames plus random traffic.
`timescale 1ns / 1ps

module tb_top;
  import crsd_pkg::*;

  // Column type bytes and the repeat-op threshold of the compressed format.
  localparam logic [7:0] TYPE_RAW    = 8'h00;
  localparam logic [7:0] TYPE_RLE    = 8'h80;
  localparam logic [7:0] TYPE_SKIP   = 8'hFF;
  localparam int         REPEAT_MIN  = 224;
  localparam int         REPEAT_BIAS = 223;

  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_BYTES = 25;

  // Where the byte parser stands inside a column.
  typedef enum logic [2:0] {
    AWAIT_TYPE,
    AWAIT_COUNT,
    AWAIT_LENGTH,
    AWAIT_SKIP,
    AWAIT_DATA,
    AWAIT_REPEAT_VALUE
  } parse_phase_e;

  // Column flavors the stimulus generator can build.
  typedef enum int {COL_SKIP, COL_RAW, COL_RLE} column_flavor_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_address;
    logic [PLANE_W-1:0] plane_mask;
    logic [BYTE_W-1:0]  pixel_value;
    logic               last;
    logic               frame_done;
  } pixel_write_t;

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  register_index;
  logic [CFG_DATA_W-1:0] write_data;

  crsd_byte_if  byte_bus ();
  crsd_write_if write_bus ();

  column_rle_sprite_decoder_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .byte_stream    (byte_bus),
    .pixel_writes   (write_bus),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  // Register copies held by the predictor.
  logic [8:0]  cfg_origin_x;
  logic [7:0]  cfg_origin_y;
  logic [8:0]  cfg_column_total;
  logic [15:0] cfg_page_segment;

  // Predictor copy of the decoder state.
  parse_phase_e phase;
  bit           rle_column;
  logic [8:0]   columns_left;
  logic [3:0]   plane;
  logic [6:0]   column_offset;
  logic [15:0]  dest_offset;
  logic [7:0]   packet_left;
  logic [7:0]   sequence_left;
  logic [5:0]   repeat_count;

  pixel_write_t expected_writes[$];
  logic [7:0]   staged_bytes[$];

  // Run bookkeeping.
  int  failures;
  int  writes_checked;
  int  bytes_parsed;
  int  frames_started;
  int  configs_applied;
  bit  quiet;          // when set, neither side idles
  int  hold_asked;     // bumped by a test to ask the receiver for a long hold-off
  int  hold_taken;

  // ---------------------------------------------------------------------------
  // Clock, and a hard limit on the run.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("timeout: %0d writes still expected", expected_writes.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Mirrors the decoder one accepted byte at a time and appends the
  // pixel writes that byte causes to expected_writes.
  // ---------------------------------------------------------------------------
  function automatic void clear_state();
    cfg_origin_x     = '0;
    cfg_origin_y     = '0;
    cfg_column_total = 9'd1;
    cfg_page_segment = 16'd40960;
    phase            = AWAIT_TYPE;
    rle_column       = 1'b0;
    columns_left     = '0;
    plane            = 4'd1;
    column_offset    = '0;
    dest_offset      = '0;
    packet_left      = '0;
    sequence_left    = '0;
    repeat_count     = '0;
  endfunction

  // Queue one write at the current destination, then step down one row.
  function automatic void queue_pixel_write(input logic [7:0] value);
    pixel_write_t w;
    logic [31:0]  linear;
    linear = 32'(cfg_page_segment) * 16 + 32'(cfg_origin_y) * ROW_STRIDE
             + 32'(dest_offset);
    w.write_address = linear[ADDR_W-1:0];
    w.plane_mask    = plane;
    w.pixel_value   = value;
    w.last          = 1'b0;
    w.frame_done    = 1'b0;
    expected_writes.push_back(w);
    dest_offset = dest_offset + 16'(ROW_STRIDE);
  endfunction

  // Close the current column; returns 1 when it was the frame's last one.
  function automatic bit close_column();
    columns_left = columns_left - 9'd1;
    phase        = AWAIT_TYPE;
    if (columns_left == 0) return 1'b1;
    // Rotate through the four planes; after plane 8 move one byte right.
    if (plane == 4'd8) begin
      plane         = 4'd1;
      column_offset = column_offset + 7'd1;
    end else begin
      plane = plane << 1;
    end
    return 1'b0;
  endfunction

  // Account for one data item of a sequence.
  function automatic bit close_item();
    phase = AWAIT_DATA;
    if (sequence_left != 0) begin
      sequence_left = sequence_left - 8'd1;
      return 1'b0;
    end
    if (packet_left != 0) begin
      phase = AWAIT_LENGTH;
      return 1'b0;
    end
    return close_column();
  endfunction

  // Returns 1 if the byte was parsed, 0 if the decoder ignores it.
  function automatic bit predict_byte(input logic [7:0] b, input logic starts_frame);
    int           mark;
    bit           ends_frame;
    pixel_write_t tail;
    mark       = expected_writes.size();
    ends_frame = 1'b0;
    if (starts_frame) begin
      columns_left  = cfg_column_total;
      plane         = 4'd1 << cfg_origin_x[1:0];
      column_offset = cfg_origin_x[8:2];
      phase         = AWAIT_TYPE;
    end
    if (columns_left == 0) return 1'b0;

    case (phase)
      AWAIT_TYPE: begin
        dest_offset = 16'(column_offset);
        if (b == TYPE_RAW || b == TYPE_RLE) begin
          rle_column = (b == TYPE_RLE);
          phase      = AWAIT_COUNT;
        end else begin
          ends_frame = close_column();
        end
      end
      AWAIT_COUNT: begin
        packet_left = b;
        phase       = AWAIT_LENGTH;
      end
      AWAIT_LENGTH: begin
        sequence_left = b;
        phase         = AWAIT_SKIP;
      end
      AWAIT_SKIP: begin
        dest_offset = dest_offset + 16'(ROW_STRIDE * b);
        packet_left = packet_left - (sequence_left + 8'd2);
        phase       = AWAIT_DATA;
      end
      AWAIT_DATA: begin
        if (rle_column && b >= REPEAT_MIN) begin
          repeat_count  = 6'(b - REPEAT_BIAS);
          sequence_left = sequence_left - 8'd1;
          phase         = AWAIT_REPEAT_VALUE;
        end else begin
          queue_pixel_write(b);
          ends_frame = close_item();
        end
      end
      AWAIT_REPEAT_VALUE: begin
        for (int i = 0; i < repeat_count; i++) queue_pixel_write(b);
        ends_frame = close_item();
      end
      default: phase = AWAIT_TYPE;
    endcase

    // Tag the final write of this byte.
    if (expected_writes.size() > mark) begin
      tail            = expected_writes.pop_back();
      tail.last       = 1'b1;
      tail.frame_done = ends_frame;
      expected_writes.push_back(tail);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: drive ready, check every write transfer against the oldest
  // expectation. A long hold-off is counted here when a test asks for one.
  // ---------------------------------------------------------------------------
  function automatic void report_failure(input string what, input pixel_write_t want,
                                         input pixel_write_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display({"%s: expected addr=%05h plane=%h pixel=%02h last=%b done=%b",
                " | got addr=%05h plane=%h pixel=%02h last=%b done=%b"},
               what, want.write_address, want.plane_mask, want.pixel_value, want.last,
               want.frame_done, got.write_address, got.plane_mask, got.pixel_value,
               got.last, got.frame_done);
  endfunction

  initial begin
    pixel_write_t got;
    pixel_write_t want;
    int           hold_left;
    hold_left       = 0;
    write_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && write_bus.valid && write_bus.ready) begin
        got.write_address = write_bus.write_address;
        got.plane_mask    = write_bus.plane_mask;
        got.pixel_value   = write_bus.pixel_value;
        got.last          = write_bus.last;
        got.frame_done    = write_bus.frame_done;
        writes_checked++;
        if (expected_writes.size() == 0) begin
          report_failure("write with nothing expected", 'x, got);
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) report_failure("write mismatch", want, got);
        end
      end
      // Hold off for a long stretch when asked, else stall at random.
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        write_bus.ready <= 1'b0;
      end else begin
        write_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the transfer, then predict its writes.
  // Valid is left high on return so back-to-back bytes need no second drive.
  task automatic send_byte(input logic [7:0] value, input logic starts_frame);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.data_byte   <= value;
    byte_bus.frame_start <= starts_frame;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    if (starts_frame) frames_started++;
    if (predict_byte(value, starts_frame)) bytes_parsed++;
  endtask

  // Send the staged bytes; the first one optionally opens a frame.
  task automatic send_staged(input bit starts_frame);
    foreach (staged_bytes[i]) send_byte(staged_bytes[i], starts_frame && (i == 0));
  endtask

  // Drop valid and wait until every expected write has arrived, then let the
  // parser settle on any trailing byte that causes no write.
  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= value;
    @(posedge clk);
  endtask

  // Write all four registers while the decoder is idle.
  task automatic set_config(input logic [8:0] ox, input logic [7:0] oy,
                            input logic [8:0] total, input logic [15:0] segment);
    drain_results();
    write_register(CFG_ORIGIN_X, 16'(ox));
    write_register(CFG_ORIGIN_Y, 16'(oy));
    write_register(CFG_COLUMN_TOTAL, 16'(total));
    write_register(CFG_PAGE_SEGMENT, segment);
    write_enable <= 1'b0;
    @(posedge clk);
    cfg_origin_x     = ox;
    cfg_origin_y     = oy;
    cfg_column_total = total;
    cfg_page_segment = segment;
    configs_applied++;
  endtask

  // Build one well-formed column into staged_bytes: a type byte, a byte count
  // that matches the sequences exactly, then 1..2 sequences of random content.
  task automatic build_column(input column_flavor_e flavor);
    int         slots;
    int         length;
    logic [7:0] count;
    logic [7:0] body[$];
    logic [7:0] odd_type;
    staged_bytes.delete();
    count = '0;
    if (flavor == COL_SKIP) begin
      // Either the explicit skip code or some other unknown type byte.
      odd_type = 8'($urandom_range(1, 255));
      if (odd_type == TYPE_RLE) odd_type = TYPE_SKIP;
      staged_bytes.push_back(($urandom_range(1) == 0) ? TYPE_SKIP : odd_type);
    end else begin
      repeat ($urandom_range(1, 2)) begin
        length = $urandom_range(0, 3);
        count  = count + 8'(length + 2);
        body.push_back(8'(length));
        // Favor large row skips now and then.
        body.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(200, 255))
                                                : 8'($urandom_range(0, 255)));
        slots = length + 1;
        while (slots > 0) begin
          if (flavor == COL_RLE && slots >= 2 && $urandom_range(2) == 0) begin
            body.push_back(8'($urandom_range(REPEAT_MIN, 255)));
            body.push_back(8'($urandom));
            slots -= 2;
          end else begin
            body.push_back((flavor == COL_RLE) ? 8'($urandom_range(0, REPEAT_MIN - 1))
                                               : 8'($urandom));
            slots -= 1;
          end
        end
      end
      staged_bytes.push_back((flavor == COL_RLE) ? TYPE_RLE : TYPE_RAW);
      staged_bytes.push_back(count);
      foreach (body[i]) staged_bytes.push_back(body[i]);
    end
  endtask

  // One frame of the configured width. Now and then a column is replaced by
  // garbage, which abandons the rest of the frame.
  task automatic send_random_frame(input int ncols, input bit allow_garbage);
    column_flavor_e flavor;
    int             pick;
    for (int c = 0; c < ncols; c++) begin
      if (allow_garbage && c > 0 && $urandom_range(99) < 8) begin
        repeat ($urandom_range(2, 8)) send_byte(8'($urandom), 1'b0);
        break;
      end
      pick   = $urandom_range(99);
      flavor = (pick < 15) ? COL_SKIP : (pick < 55) ? COL_RAW : COL_RLE;
      build_column(flavor);
      send_staged(c == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Registers at their reset values: one-column frame, bytes outside a frame ignored.
  task automatic test_reset_defaults();
    send_byte(8'h5C, 1'b0);
    send_byte(8'hA3, 1'b0);
    staged_bytes = '{TYPE_RAW, 8'd2, 8'd0, 8'd0, 8'h00};
    send_staged(1'b1);
    send_byte(8'h80, 1'b0);
  endtask

  // Field and register extremes; raw data, plain bytes in an RLE column, the
  // longest and shortest repeats, and the largest row skip.
  task automatic test_field_extremes();
    set_config(9'd319, 8'd199, 9'd2, 16'hFFFF);
    staged_bytes = '{TYPE_RAW, 8'd2, 8'd0, 8'd0, 8'hFF};
    send_staged(1'b1);
    staged_bytes = '{TYPE_RLE, 8'd6, 8'd4, 8'd255, 8'd223,
                     8'd255, 8'h11, 8'd224, 8'hEE};
    send_staged(1'b0);
  endtask

  // Sequence underflow, restart in the middle of a frame, unknown column type,
  // a skipped final column and a zero column total, which opens no frame.
  task automatic test_special_cases();
    set_config(9'd2, 8'd0, 9'd3, 16'h0000);
    send_byte(8'h00, 1'b0);
    // A repeat op on a one-item sequence wraps the item count; the column runs on.
    staged_bytes = '{TYPE_RLE, 8'd2, 8'd0, 8'd0, 8'hE1, 8'h33, 8'h44};
    send_staged(1'b1);
    // Restart mid-column; every column is skipped, so nothing carries frame_done.
    staged_bytes = '{8'h37, TYPE_SKIP, TYPE_SKIP};
    send_staged(1'b1);
    // A zero total opens no frame, so the decoder ignores all of these bytes.
    // Their four largest row skips would carry the row offset past 16 bits.
    set_config(9'd1, 8'd100, 9'd0, 16'hFFFF);
    staged_bytes = '{TYPE_RAW, 8'd8, 8'd0, 8'd255, 8'h99, 8'd0, 8'd255, 8'h9A,
                     8'd0, 8'd255, 8'h9B, 8'd0, 8'd255, 8'h9C};
    send_staged(1'b1);
  endtask

  // Receiver holds off while long repeats fill the decoder; then the sender
  // pauses mid-frame until every write is out before finishing the frame.
  task automatic test_backpressure();
    set_config(9'd0, 8'd50, 9'd2, 16'hA000);
    hold_asked++;
    staged_bytes = '{TYPE_RLE, 8'd9, 8'd7, 8'd3, 8'd255, 8'h21, 8'd255, 8'h22,
                     8'd255, 8'h23, 8'd255, 8'h24};
    send_staged(1'b1);
    drain_results();
    staged_bytes = '{TYPE_RAW, 8'd2, 8'd0, 8'd5, 8'h5A};
    send_staged(1'b0);
  endtask

  // Nine columns from near the right edge: the plane walks through all four
  // values and the byte offset advances twice. Skipped columns keep it short;
  // the last column writes.
  task automatic test_plane_rotation();
    set_config(9'd318, 8'd0, 9'd9, 16'h0000);
    for (int c = 0; c < 9; c++) begin
      build_column((c == 8) ? COL_RAW : COL_SKIP);
      send_staged(c == 0);
    end
  endtask

  // Random registers and frames; the first round runs with no idling on either side.
  task automatic test_random_traffic();
    int start_count;
    int round;
    start_count = bytes_parsed;
    round       = 0;
    while (bytes_parsed - start_count < RANDOM_BYTES) begin
      set_config(9'($urandom_range(0, 319)),
                 (round == 1) ? 8'd199 : 8'($urandom_range(0, 199)),
                 9'($urandom_range(1, 3)), 16'($urandom));
      quiet = (round == 0);
      repeat ($urandom_range(1, 3)) begin
        send_random_frame(cfg_column_total, 1'b1);
        // Noise between frames is ignored once a frame is complete.
        if ($urandom_range(4) == 0 && columns_left == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
      round++;
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    failures        = 0;
    writes_checked  = 0;
    bytes_parsed    = 0;
    frames_started  = 0;
    configs_applied = 0;
    quiet           = 1'b0;
    hold_asked      = 0;
    hold_taken      = 0;
    clear_state();
    byte_bus.valid       <= 1'b0;
    byte_bus.data_byte   <= '0;
    byte_bus.frame_start <= 1'b0;
    write_enable         <= 1'b0;
    register_index       <= '0;
    write_data           <= '0;
    rst                  <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_backpressure();
    test_plane_rotation();
    test_random_traffic();

    drain_results();
    if (expected_writes.size() != 0) begin
      failures += expected_writes.size();
      $display("%0d expected writes never arrived", expected_writes.size());
    end
    $display("covered %0d parsed bytes over %0d frames and %0d register settings",
             bytes_parsed, frames_started, configs_applied);
    $display("checked %0d pixel writes, %0d failures", writes_checked, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
